### hdl/edf_pkg.sv
// edf_pkg: shared types, constants and arithmetic helpers for the emphasis filter pair
// used by every module under hdl; depends on nothing
package edf_pkg;

  localparam int unsigned CH_W      = 4;
  localparam int unsigned SMP_W     = 24;
  localparam int unsigned ST_W      = 32;
  localparam int unsigned COEF_W    = 48;
  localparam int unsigned PAR_W     = 24;
  localparam int unsigned LANES     = 4;
  localparam int unsigned ACC_W     = 34;
  localparam int unsigned DIF_W     = 33;
  localparam int unsigned MB_W      = 26;
  localparam int unsigned PROD_W    = 60;
  localparam int unsigned GPROD_W   = 46;
  localparam int unsigned HG_W      = 21;
  localparam int unsigned LG_W      = 24;
  localparam int unsigned ADDR_W    = 6;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned FRAC_G    = 16;
  localparam int unsigned FRAC_K    = 23;
  localparam int unsigned FRAC_GAIN = 20;

  localparam logic signed [MB_W-1:0] ONE_GAIN = 26'sh0100000;

  localparam logic [COEF_W-1:0] COEF_RST = 48'd8388608;
  localparam logic [HG_W-1:0]   HG_RST   = 21'd104858;
  localparam logic [LG_W-1:0]   LG_RST   = 24'd10485760;
  localparam logic [LG_W-1:0]   IHG_RST  = 24'd10485760;
  localparam logic [HG_W-1:0]   ILG_RST  = 21'd104858;

  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;
  localparam logic signed [63:0] MAX24 = 64'sd8388607;
  localparam logic signed [63:0] MIN24 = -64'sd8388608;

  typedef enum logic [2:0] {
    REG_COEF_HM  = 3'd0,
    REG_COEF_LC  = 3'd1,
    REG_COEF_LM  = 3'd2,
    REG_COEF_HC  = 3'd3,
    REG_HG       = 3'd4,
    REG_LG       = 3'd5,
    REG_IHG      = 3'd6,
    REG_ILG      = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GX,
    ST_KY,
    ST_GD,
    ST_GAIN,
    ST_SUM
  } state_e;

  typedef enum logic [1:0] {
    OP_GX,
    OP_KY,
    OP_GD,
    OP_GAIN
  } mul_op_e;

  typedef struct packed {
    logic [LANES-1:0][COEF_W-1:0] coef;
    logic [HG_W-1:0]              hg;
    logic [LG_W-1:0]              lg;
    logic [LG_W-1:0]              ihg;
    logic [HG_W-1:0]              ilg;
  } cfg_t;

  typedef struct packed {
    logic    load;
    mul_op_e op;
    logic    acc_en;
    logic    y_en;
    logic    ns_en;
    logic    prod_en;
    logic    out_en;
  } cmd_t;

  // round half up, then floor
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [ST_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > MAX32) begin
      r = MAX32;
    end else if (v < MIN32) begin
      r = MIN32;
    end else begin
      r = v;
    end
    return r[ST_W-1:0];
  endfunction

  function automatic logic signed [SMP_W-1:0] sat24(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > MAX24) begin
      r = MAX24;
    end else if (v < MIN24) begin
      r = MIN24;
    end else begin
      r = v;
    end
    return r[SMP_W-1:0];
  endfunction

endpackage

### hdl/emphasis_deemphasis_filter_pair_top.sv
// each item steps through four phases that reuse the four multiplier lanes (g*x, times k,
// state update, shelf weights) and a final sum that waits while the output register is full;
// a new item is accepted only after the previous one has finished its final sum
// the next item is taken while a finished result waits in the output register
// reset: registers to defaults; filter states read as zero via per-channel valid bits
module emphasis_deemphasis_filter_pair_top #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [47:0]                s_axis_tdata,   // dry_sample, return_sample
  input  logic [edf_pkg::CH_W-1:0]   s_axis_tuser,   // channel
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [47:0]                m_axis_tdata,   // send_sample, out_sample
  output logic [edf_pkg::CH_W-1:0]   m_axis_tuser,   // channel_out
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [edf_pkg::ADDR_W-1:0] paddr,
  input  logic [edf_pkg::DATA_W-1:0] pwdata,
  output logic [edf_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import edf_pkg::*;

  cfg_t                    cfg;
  cmd_t                    cmd;
  logic signed [SMP_W-1:0] send_s, res_s;

  assign pready = 1'b1;

  edf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  edf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .cmd_o     (cmd)
  );

  edf_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .cmd_i  (cmd),
    .ch_i   (s_axis_tuser),
    .dry_i  (s_axis_tdata[SMP_W-1:0]),
    .rtn_i  (s_axis_tdata[2*SMP_W-1:SMP_W]),
    .ch_o   (m_axis_tuser),
    .send_o (send_s),
    .res_o  (res_s)
  );

  assign m_axis_tdata = {res_s, send_s};

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while another is in work");

  a_phase_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> ##4 cmd.prod_en)
    else $error("shelf products not taken four cycles after acceptance");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_en |-> !m_axis_tvalid || m_axis_tready)
    else $error("result register overwritten before it was taken");

endmodule

### hdl/edf_regs.sv
// edf_regs: configuration register file behind the register bus port
// depends on edf_pkg
module edf_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [edf_pkg::ADDR_W-1:0] paddr,
  input  logic [edf_pkg::DATA_W-1:0] pwdata,
  output logic [edf_pkg::DATA_W-1:0] prdata,
  output edf_pkg::cfg_t              cfg_o
);
  import edf_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr;

  assign idx = reg_idx_e'(paddr[ADDR_W-1:3]);
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef <= {LANES{COEF_RST}};
      cfg_q.hg   <= HG_RST;
      cfg_q.lg   <= LG_RST;
      cfg_q.ihg  <= IHG_RST;
      cfg_q.ilg  <= ILG_RST;
    end else if (wr) begin
      case (idx)
        REG_COEF_HM: cfg_q.coef[0] <= pwdata[COEF_W-1:0];
        REG_COEF_LC: cfg_q.coef[1] <= pwdata[COEF_W-1:0];
        REG_COEF_LM: cfg_q.coef[2] <= pwdata[COEF_W-1:0];
        REG_COEF_HC: cfg_q.coef[3] <= pwdata[COEF_W-1:0];
        REG_HG:      cfg_q.hg      <= pwdata[HG_W-1:0];
        REG_LG:      cfg_q.lg      <= pwdata[LG_W-1:0];
        REG_IHG:     cfg_q.ihg     <= pwdata[LG_W-1:0];
        REG_ILG:     cfg_q.ilg     <= pwdata[HG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COEF_HM: prdata = DATA_W'(cfg_q.coef[0]);
      REG_COEF_LC: prdata = DATA_W'(cfg_q.coef[1]);
      REG_COEF_LM: prdata = DATA_W'(cfg_q.coef[2]);
      REG_COEF_HC: prdata = DATA_W'(cfg_q.coef[3]);
      REG_HG:      prdata = DATA_W'(cfg_q.hg);
      REG_LG:      prdata = DATA_W'(cfg_q.lg);
      REG_IHG:     prdata = DATA_W'(cfg_q.ihg);
      REG_ILG:     prdata = DATA_W'(cfg_q.ilg);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/edf_ctrl.sv
// edf_ctrl: sequencer stepping one item through the four multiply phases
// depends on edf_pkg
module edf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic          m_ready_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  output edf_pkg::cmd_t cmd_o
);
  import edf_pkg::*;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free;

  assign out_free = !out_vld_q || m_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_valid_i) state_d = ST_GX;
      ST_GX:   state_d = ST_KY;
      ST_KY:   state_d = ST_GD;
      ST_GD:   state_d = ST_GAIN;
      ST_GAIN: state_d = ST_SUM;
      ST_SUM:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    cmd_o.op  = OP_GX;
    s_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.load = s_valid_i;
      end
      ST_GX: begin
        cmd_o.op     = OP_GX;
        cmd_o.acc_en = 1'b1;
      end
      ST_KY: begin
        cmd_o.op   = OP_KY;
        cmd_o.y_en = 1'b1;
      end
      ST_GD: begin
        cmd_o.op    = OP_GD;
        cmd_o.ns_en = 1'b1;
      end
      ST_GAIN: begin
        cmd_o.op      = OP_GAIN;
        cmd_o.prod_en = 1'b1;
      end
      ST_SUM: begin
        cmd_o.out_en = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.out_en) begin
      out_vld_d = 1'b1;
    end else if (m_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign m_valid_o = out_vld_q;

endmodule

### hdl/edf_dp.sv
// edf_dp: four multiplier lanes, filter state memory, gain sums and result register
// depends on edf_pkg; driven by edf_ctrl commands
module edf_dp #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  edf_pkg::cfg_t                       cfg_i,
  input  edf_pkg::cmd_t                       cmd_i,
  input  logic [edf_pkg::CH_W-1:0]            ch_i,
  input  logic signed [edf_pkg::SMP_W-1:0]    dry_i,
  input  logic signed [edf_pkg::SMP_W-1:0]    rtn_i,
  output logic [edf_pkg::CH_W-1:0]            ch_o,
  output logic signed [edf_pkg::SMP_W-1:0]    send_o,
  output logic signed [edf_pkg::SMP_W-1:0]    res_o
);
  import edf_pkg::*;

  localparam int unsigned ROW_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CH_N  = 2 ** CH_W;
  localparam int unsigned ROW_BITS = LANES * ST_W;

  logic [ROW_W-1:0] row_lut [CH_N];

  for (genvar i = 0; i < CH_N; i++) begin : g_row
    assign row_lut[i] = ROW_W'(i % CHANNELS);
  end

  logic [ROW_BITS-1:0] mem [CHANNELS];
  logic [CHANNELS-1:0] vld_q;

  logic [CH_W-1:0]          ch_q;
  logic signed [SMP_W-1:0]  dry_q, rtn_q;
  logic [ROW_W-1:0]         row_q, row_in;
  logic [ROW_BITS-1:0]      rd_q;
  logic                     rd_vld_q;

  logic signed [ACC_W-1:0]   acc_q [LANES];
  logic signed [ST_W-1:0]    y_q   [LANES];
  logic signed [PROD_W-1:0]  prod_q [LANES];
  logic signed [GPROD_W-1:0] pd_q, pr_q;

  logic signed [SMP_W-1:0]   x_s   [LANES];
  logic signed [ST_W-1:0]    st_s  [LANES];
  logic signed [DIF_W-1:0]   dif_s [LANES];
  logic signed [DIF_W-1:0]   trm_s [LANES];
  logic signed [MB_W-1:0]    gd_s  [LANES];
  logic signed [ACC_W-1:0]   ma_s  [LANES];
  logic signed [MB_W-1:0]    mb_s  [LANES];
  logic signed [PROD_W-1:0]  p_s   [LANES];
  logic signed [ACC_W-1:0]   acc_n [LANES];
  logic signed [ST_W-1:0]    y_n   [LANES];
  logic [ROW_BITS-1:0]       ns_row;

  logic signed [GPROD_W-1:0] pd_n, pr_n;
  logic signed [63:0]        send_sum, res_sum;

  logic [CH_W-1:0]           ch_out_q;
  logic signed [SMP_W-1:0]   send_q, res_q;

  assign row_in = row_lut[ch_i];

  // shelf weights: (1-hg), (lg-1), (1-ilg), (ihg-1)
  assign gd_s[0] = ONE_GAIN - signed'(MB_W'(cfg_i.hg));
  assign gd_s[1] = signed'(MB_W'(cfg_i.lg)) - ONE_GAIN;
  assign gd_s[2] = ONE_GAIN - signed'(MB_W'(cfg_i.ilg));
  assign gd_s[3] = signed'(MB_W'(cfg_i.ihg)) - ONE_GAIN;

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      x_s[j]   = (j < 2) ? dry_q : rtn_q;
      st_s[j]  = rd_vld_q ? signed'(rd_q[j*ST_W +: ST_W]) : '0;
      dif_s[j] = DIF_W'(x_s[j]) - DIF_W'(y_q[j]);
      trm_s[j] = (j < 2) ? DIF_W'(y_q[j]) : dif_s[j];
      case (cmd_i.op)
        OP_GX: begin
          ma_s[j] = ACC_W'(x_s[j]);
          mb_s[j] = signed'(MB_W'(cfg_i.coef[j][COEF_W-1:PAR_W]));
        end
        OP_KY: begin
          ma_s[j] = acc_q[j];
          mb_s[j] = signed'(MB_W'(cfg_i.coef[j][PAR_W-1:0]));
        end
        OP_GD: begin
          ma_s[j] = ACC_W'(dif_s[j]);
          mb_s[j] = signed'(MB_W'(cfg_i.coef[j][COEF_W-1:PAR_W]));
        end
        OP_GAIN: begin
          ma_s[j] = ACC_W'(trm_s[j]);
          mb_s[j] = gd_s[j];
        end
        default: begin
          ma_s[j] = '0;
          mb_s[j] = '0;
        end
      endcase
      p_s[j]   = PROD_W'(ma_s[j]) * PROD_W'(mb_s[j]);
      acc_n[j] = ACC_W'(rnd_shr(64'(p_s[j]), FRAC_G) + 64'(st_s[j]));
      y_n[j]   = sat32(rnd_shr(64'(p_s[j]), FRAC_K));
      ns_row[j*ST_W +: ST_W] = sat32(rnd_shr(64'(p_s[j]), FRAC_G) + 64'(y_q[j]));
    end
  end

  assign pd_n = GPROD_W'(dry_q) * GPROD_W'(signed'({1'b0, cfg_i.hg}));
  assign pr_n = GPROD_W'(rtn_q) * GPROD_W'(signed'({1'b0, cfg_i.ilg}));

  assign send_sum = 64'(pd_q) + 64'(prod_q[0]) + 64'(prod_q[1]);
  assign res_sum  = 64'(pr_q) + 64'(prod_q[2]) + 64'(prod_q[3]);

  // state memory, one row per channel
  always_ff @(posedge clk_i) begin
    if (cmd_i.ns_en) begin
      mem[row_q] <= ns_row;
    end
    if (cmd_i.load) begin
      rd_q     <= mem[row_in];
      rd_vld_q <= vld_q[row_in];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.ns_en) begin
      vld_q[row_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q  <= ch_i;
      dry_q <= dry_i;
      rtn_q <= rtn_i;
      row_q <= row_in;
    end
    if (cmd_i.acc_en) begin
      acc_q <= acc_n;
    end
    if (cmd_i.y_en) begin
      y_q <= y_n;
    end
    if (cmd_i.prod_en) begin
      prod_q <= p_s;
      pd_q   <= pd_n;
      pr_q   <= pr_n;
    end
    if (cmd_i.out_en) begin
      ch_out_q <= ch_q;
      send_q   <= sat24(rnd_shr(send_sum, FRAC_GAIN));
      res_q    <= sat24(rnd_shr(res_sum, FRAC_GAIN));
    end
  end

  assign ch_o   = ch_out_q;
  assign send_o = send_q;
  assign res_o  = res_q;

endmodule
